// ----- hdl/median_filter_3x3_assert.svh -----
// ----------------------------------------------------------------------------
// median_filter_3x3 assertion macros
// shared property forms for the checker of the median filter
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_3X3_ASSERT_SVH
`define MEDIAN_FILTER_3X3_ASSERT_SVH

// consequent must hold in the cycle after the antecedent, outside reset
`define MF3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("median filter check failed");

// same form, also checked across reset
`define MF3_ASSERT_NEXT_ANY(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("median filter check failed");

`endif

// ----- hdl/mf3_pkg.sv -----
// ----------------------------------------------------------------------------
// mf3_pkg
// types, constants and compare-select helpers of the 3x3 median filter
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int PIXEL_BITS   = 8;
  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_HEIGHT   = 2048;
  localparam int DIM_BITS     = 12;
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int ROW_BITS     = $clog2(MAX_HEIGHT) + 1;
  localparam int CNT_BITS     = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int CFG_IDX_BITS = 4;
  localparam int MIN_DIM      = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [COL_BITS-1:0]   col_t;
  typedef logic [ROW_BITS-1:0]   row_t;
  typedef logic [DIM_BITS-1:0]   dim_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  typedef struct packed {
    pix_t lo;
    pix_t mi;
    pix_t hi;
  } col3_t;

  // window control from the top level pipeline
  typedef struct packed {
    logic shift;
    logic capture;
  } win_ctl_t;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic col3_t sort3(input pix_t a, input pix_t b, input pix_t c);
    col3_t s;
    s.lo = min3(a, b, c);
    s.hi = max3(a, b, c);
    s.mi = med3(a, b, c);
    return s;
  endfunction

endpackage

// ----- hdl/mf3_window.sv -----
// ----------------------------------------------------------------------------
// mf3_window
// 3x3 window of sorted columns and the first median reduction stage
// ----------------------------------------------------------------------------
module mf3_window
  import mf3_pkg::*;
(
  input  logic     clk,
  input  win_ctl_t ctl,
  input  pix_t     col_top,
  input  pix_t     col_mid,
  input  pix_t     col_bot,
  output pix_t     lo_r,
  output pix_t     md_r,
  output pix_t     hi_r,
  output pix_t     ctr_r
);

  // column 0 oldest, column 2 newest; each column kept sorted
  col3_t win_r [3];
  pix_t  raw_mid_r [2];  // unsorted middle row of columns 1 and 2
  col3_t new_col;

  assign new_col = sort3(col_top, col_mid, col_bot);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      win_r[0]     <= win_r[1];
      win_r[1]     <= win_r[2];
      win_r[2]     <= new_col;
      raw_mid_r[0] <= raw_mid_r[1];
      raw_mid_r[1] <= col_mid;
    end
  end

  // max of mins, median of medians, min of maxes
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      lo_r  <= max3(win_r[0].lo, win_r[1].lo, win_r[2].lo);
      md_r  <= med3(win_r[0].mi, win_r[1].mi, win_r[2].mi);
      hi_r  <= min3(win_r[0].hi, win_r[1].hi, win_r[2].hi);
      ctr_r <= raw_mid_r[0];
    end
  end

endmodule

// ----- hdl/median_filter_3x3.sv -----
// ----------------------------------------------------------------------------
// median_filter_3x3
// raster-order 3x3 median filter with two line stores, border passthrough
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_pixel_in, in_flush
//  out     | output    | out_valid / out_ready | out_pixel_out, out_frame_last
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  one item per cycle unless the output stalls or a cfg write holds off input;
//  each result lags the input stream by width+1 items
//  the line stores are single-write, single-read rams with registered read;
//  a store to the column being read in the same cycle is forwarded
//  in_ready drops in the cycle after a cfg transfer while width*height settles
//  a stalled output backs the pipeline up stage by stage; reset clears the valid
//  bits and position and reloads the frame size; the line stores are not cleared
module median_filter_3x3
  import mf3_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  pix_t                    in_pixel_in,
  input  logic                    in_flush,
  output logic                    out_valid,
  input  logic                    out_ready,
  output pix_t                    out_pixel_out,
  output logic                    out_frame_last,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [DIM_BITS-1:0]     cfg_data
);

  function automatic dim_t clamp_dim(input dim_t v, input dim_t hi);
    dim_t r;
    r = v;
    if (v < DIM_BITS'(MIN_DIM)) r = DIM_BITS'(MIN_DIM);
    else if (v > hi)            r = hi;
    return r;
  endfunction

  // configuration
  dim_t width_r, width_m1_r, height_r, height_m1_r;
  cnt_t area_m1_r;
  logic cfg_hold_r;
  dim_t cfg_w, cfg_h;
  logic cfg_xfer;

  // position tracking
  col_t col_r, col_nxt;
  row_t row_r, row_nxt;
  cnt_t cnt_r, cnt_nxt;

  // pipeline stages
  logic s1_valid_r, s1_emit_r, s1_border_r, s1_last_r, s1_flush_r;
  pix_t s1_pix_r;
  col_t s1_col_r;
  logic fwd_r;
  pix_t fwd_a_r, fwd_b_r;
  logic s2_valid_r, s2_border_r, s2_last_r;
  logic s3_valid_r, s3_border_r, s3_last_r;
  logic out_valid_r, out_last_r;
  pix_t out_pixel_r;

  // handshake chain
  logic adv_out, s3_go, s3_free, s2_go, s2_free, s1_go, s1_free, acc;

  // stage-0 position logic
  logic wrap_in, wrap_out, emit, border, is_last;
  col_t col_w;
  row_t row_w, r_pos;
  dim_t col_inc, c_pos;

  // line stores
  pix_t line_store_a [MAX_WIDTH];
  pix_t line_store_b [MAX_WIDTH];
  pix_t rd_a_r, rd_b_r;
  pix_t top, mid, bot;
  logic st_we;

  // window and median
  win_ctl_t win_ctl;
  pix_t     lo, md, hi, ctr;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign cfg_w     = clamp_dim(cfg_data, DIM_BITS'(MAX_WIDTH));
  assign cfg_h     = clamp_dim(cfg_data, DIM_BITS'(MAX_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RESET;
      width_m1_r  <= WIDTH_RESET - DIM_BITS'(1);
      height_r    <= HEIGHT_RESET;
      height_m1_r <= HEIGHT_RESET - DIM_BITS'(1);
      area_m1_r   <= CNT_BITS'(WIDTH_RESET * HEIGHT_RESET - 1);
      cfg_hold_r  <= 1'b0;
    end else begin
      cfg_hold_r <= cfg_xfer;
      if (cfg_xfer && cfg_index == REG_FRAME_WIDTH) begin
        width_r    <= cfg_w;
        width_m1_r <= cfg_w - DIM_BITS'(1);
      end
      if (cfg_xfer && cfg_index == REG_FRAME_HEIGHT) begin
        height_r    <= cfg_h;
        height_m1_r <= cfg_h - DIM_BITS'(1);
      end
      if (cfg_hold_r) begin
        area_m1_r <= CNT_BITS'({{DIM_BITS{1'b0}}, width_r} * {{DIM_BITS{1'b0}}, height_r}
                               - (2*DIM_BITS)'(1));
      end
    end
  end

  // ready chain, output side first
  assign adv_out  = !out_valid_r || out_ready;
  assign s3_go    = s3_valid_r && adv_out;
  assign s3_free  = !s3_valid_r || adv_out;
  assign s2_go    = s2_valid_r && s3_free;
  assign s2_free  = !s2_valid_r || s3_free;
  assign s1_go    = s1_valid_r && s2_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_ready = s1_free && !cfg_hold_r;
  assign acc      = in_valid && in_ready;

  // position of the incoming item, wrapped if the width shrank
  always_comb begin
    wrap_in  = {1'b0, col_r} >= width_r;
    col_w    = wrap_in ? '0 : col_r;
    row_w    = wrap_in ? row_r + ROW_BITS'(1) : row_r;
    col_inc  = {1'b0, col_w} + DIM_BITS'(1);
    wrap_out = col_inc >= width_r;
    emit     = !(row_w == '0 || (row_w == ROW_BITS'(1) && col_w == '0));
    // centre of the window sits one row up and one column back, or at the end of the row two above
    c_pos    = (col_w != '0) ? {1'b0, col_w} - DIM_BITS'(1) : width_m1_r;
    r_pos    = (col_w != '0) ? row_w - ROW_BITS'(1) : row_w - ROW_BITS'(2);
    border   = r_pos == '0 || c_pos == '0 || r_pos >= height_m1_r ||
               c_pos >= width_m1_r;
    is_last  = emit && cnt_r >= area_m1_r;
    col_nxt  = wrap_out ? '0 : col_inc[COL_BITS-1:0];
    row_nxt  = wrap_out ? row_w + ROW_BITS'(1) : row_w;
    cnt_nxt  = cnt_r;
    if (emit) begin
      cnt_nxt = cnt_r + CNT_BITS'(1);
    end
    if (is_last) begin
      col_nxt = '0;
      row_nxt = '0;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      cnt_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // line stores: read at transfer, write back when a non-flush item leaves stage 1
  assign mid   = fwd_r ? fwd_a_r : rd_a_r;
  assign top   = fwd_r ? fwd_b_r : rd_b_r;
  assign bot   = s1_flush_r ? '0 : s1_pix_r;
  assign st_we = s1_go && !s1_flush_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_a_r <= line_store_a[col_w];
      rd_b_r <= line_store_b[col_w];
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      line_store_a[s1_col_r] <= s1_pix_r;
      line_store_b[s1_col_r] <= mid;
    end
  end

  // forward a store to the same column that lands with the read
  always_ff @(posedge clk) begin
    if (acc) begin
      fwd_r   <= st_we && (s1_col_r == col_w);
      fwd_a_r <= s1_pix_r;
      fwd_b_r <= mid;
    end
  end

  // stage 1: memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_emit_r   <= emit;
      s1_border_r <= border;
      s1_last_r   <= is_last;
      s1_flush_r  <= in_flush;
      s1_pix_r    <= in_pixel_in;
      s1_col_r    <= col_w;
    end
  end

  // stage 2: window; items without a result only shift it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_valid_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_border_r <= s1_border_r;
      s2_last_r   <= s1_last_r;
    end
  end

  assign win_ctl.shift   = s1_go;
  assign win_ctl.capture = s2_go;

  mf3_window u_window (
    .clk     (clk),
    .ctl     (win_ctl),
    .col_top (top),
    .col_mid (mid),
    .col_bot (bot),
    .lo_r    (lo),
    .md_r    (md),
    .hi_r    (hi),
    .ctr_r   (ctr)
  );

  // stage 3: reduced triple
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_free) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      s3_border_r <= s2_border_r;
      s3_last_r   <= s2_last_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_go) begin
      out_pixel_r <= s3_border_r ? ctr : med3(lo, md, hi);
      out_last_r  <= s3_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pixel_r;
  assign out_frame_last = out_last_r;

endmodule

// ----- hdl/mf3_checker.sv -----
// ----------------------------------------------------------------------------
// mf3_checker
// port-level checks of the median filter, bound to the top level
// ----------------------------------------------------------------------------
`include "median_filter_3x3_assert.svh"

module mf3_checker
  import mf3_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input pix_t in_pixel_in,
  input logic in_flush,
  input logic out_valid,
  input logic out_ready,
  input pix_t out_pixel_out,
  input logic out_frame_last,
  input logic cfg_valid,
  input logic cfg_ready
);

  logic [PIXEL_BITS:0] in_payload;
  logic [PIXEL_BITS:0] out_payload;

  assign in_payload  = {in_pixel_in, in_flush};
  assign out_payload = {out_pixel_out, out_frame_last};

  // an offered item waits unchanged until its transfer
  `MF3_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid && $stable(in_payload))

  // a result held back keeps its place
  `MF3_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // and its value
  `MF3_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_payload))

  // input is held off while the frame area settles after a register write
  `MF3_ASSERT_NEXT(a_cfg_holdoff, clk, rst_n, cfg_valid && cfg_ready, !in_ready)

  // pipeline comes out of reset empty
  `MF3_ASSERT_NEXT_ANY(a_reset_empty, clk, !rst_n, !out_valid)

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_pixel_in    (in_pixel_in),
  .in_flush       (in_flush),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_pixel_out  (out_pixel_out),
  .out_frame_last (out_frame_last),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready)
);
